@@ src/sbus_frame_decoder_top_assert.svh @@
// Assertion macros for the S.Bus frame decoder.
`ifndef SBUS_FRAME_DECODER_TOP_ASSERT_SVH
`define SBUS_FRAME_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SFD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SFD_ASSERT_SAME(lbl, ante, cons, msg)

`define SFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/sfd_pkg.sv @@
// Shared constants and types of the S.Bus frame decoder.
package sfd_pkg;

   localparam int FRAME_BYTES    = 25;
   localparam int CHANNEL_COUNT  = 16;
   localparam int CHAN_IDX_W     = 4;
   localparam int POS_W          = 5;
   localparam int RAW_W          = 11;
   localparam int NORM_W         = 16;
   localparam int COUNT_W        = 32;

   localparam logic [7:0] START_BYTE   = 8'h0F;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;
   localparam int         FLAG_INDEX   = 23;
   localparam int         FAILSAFE_POS = 3;
   localparam int         LOST_POS     = 2;

   // normalize: floor((raw-172)*32768/1639) - 16384
   //   = 20*m + floor((-12*m + 14*1639) / 1639) - 14 - 16384, m = raw - 172
   localparam int RAW_MIN      = 172;
   localparam int SPAN_BIAS    = 22946;  // 14 * 1639
   localparam int BIAS_STEPS   = 14;
   localparam int NORM_OFFSET  = 16384;
   localparam int RECIP        = 20473;  // ceil(2^25 / 1639)
   localparam int RECIP_SHIFT  = 25;

   typedef struct packed {
      logic                  accept;
      logic                  load_out;
      logic [CHAN_IDX_W-1:0] ch_idx;
   } sfd_cmd_type;

   typedef struct packed {
      logic frame_done;
   } sfd_status_type;

endpackage

@@ src/sbus_frame_decoder_top.sv @@
// Top level of the S.Bus frame decoder.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  rx_byte (one serial byte per word)
//   rsp_      out        rsp_valid/rsp_stall  channel_index .. last (16 words per frame)
//
// A byte that does not complete a frame is taken without a stall, back to back.
// The byte that completes a frame starts 16 result words, one per cycle unless
// rsp_stall holds them, from the channel table through the normalizer into the
// output register; req_stall stays high until the sixteenth word is loaded.
// rsp_stall holds the output register and pauses the channel sequencer.
// Synchronous reset clears position, counters and channel table; no clearing pass.
module sbus_frame_decoder_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sfd_pkg::CHAN_IDX_W-1:0]       rsp_channel_index,
   output logic [sfd_pkg::RAW_W-1:0]            rsp_raw_value,
   output logic signed [sfd_pkg::NORM_W-1:0]    rsp_normalized,
   output logic                                 rsp_failsafe,
   output logic                                 rsp_frame_lost,
   output logic [sfd_pkg::COUNT_W-1:0]          rsp_good_frames,
   output logic [sfd_pkg::COUNT_W-1:0]          rsp_bad_frames,
   output logic                                 rsp_last
);

   `include "sbus_frame_decoder_top_assert.svh"

   sfd_pkg::sfd_cmd_type    cmd;
   sfd_pkg::sfd_status_type status;

   sfd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_rx_byte       (req_rx_byte),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_normalized    (rsp_normalized),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_frame_lost    (rsp_frame_lost),
      .rsp_good_frames   (rsp_good_frames),
      .rsp_bad_frames    (rsp_bad_frames),
      .rsp_last          (rsp_last)
   );

   // no byte may enter while result words are being loaded
   `SFD_ASSERT_SAME(a_no_accept_during_emit, cmd.load_out, req_stall, "byte taken during emit")

   `SFD_ASSERT_NEXT(a_done_starts_emit, status.frame_done, req_stall, "frame done without emit")

   // words of one frame follow without gaps when the sink keeps up
   `SFD_ASSERT_NEXT(a_emit_continues, rsp_valid && !rsp_stall && !rsp_last, rsp_valid,
                    "gap inside a frame's result words")

endmodule

@@ src/sfd_controller.sv @@
// Sequencer: takes bytes, then steps through the sixteen channel results.
module sfd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  sfd_pkg::sfd_status_type status,
   output sfd_pkg::sfd_cmd_type    cmd
);

   typedef enum logic {
      ST_RECEIVE,
      ST_EMIT
   } state_type;

   state_type                       state_ff, state_in;
   logic [sfd_pkg::CHAN_IDX_W-1:0]  ch_ff, ch_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            load;

   assign req_stall = (state_ff == ST_EMIT);
   assign rsp_valid = rsp_valid_ff;
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd.accept   = req_valid && !req_stall;
      cmd.load_out = load;
      cmd.ch_idx   = ch_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_RECEIVE: begin
            if (status.frame_done) begin
               state_in = ST_EMIT;
               ch_in    = '0;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               ch_in        = ch_ff + 1'b1;
               if (ch_ff == sfd_pkg::CHAN_IDX_W'(sfd_pkg::CHANNEL_COUNT - 1)) begin
                  state_in = ST_RECEIVE;
               end
            end
         end
         default: begin
            state_in = ST_RECEIVE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RECEIVE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/sfd_datapath.sv @@
// Frame store, channel table, counters, normalizer and result register.
module sfd_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sfd_pkg::sfd_cmd_type                 cmd,
   output sfd_pkg::sfd_status_type              status,
   input  logic [7:0]                           req_rx_byte,
   output logic [sfd_pkg::CHAN_IDX_W-1:0]       rsp_channel_index,
   output logic [sfd_pkg::RAW_W-1:0]            rsp_raw_value,
   output logic signed [sfd_pkg::NORM_W-1:0]    rsp_normalized,
   output logic                                 rsp_failsafe,
   output logic                                 rsp_frame_lost,
   output logic [sfd_pkg::COUNT_W-1:0]          rsp_good_frames,
   output logic [sfd_pkg::COUNT_W-1:0]          rsp_bad_frames,
   output logic                                 rsp_last
);

   logic [7:0]                      store_ff [sfd_pkg::FRAME_BYTES];
   logic [sfd_pkg::POS_W-1:0]       pos_ff, pos_in, pos_eff;
   logic                            prev_zero_ff;
   logic [sfd_pkg::RAW_W-1:0]       chan_ff [sfd_pkg::CHANNEL_COUNT];
   logic [sfd_pkg::RAW_W-1:0]       unpacked [sfd_pkg::CHANNEL_COUNT];
   logic [sfd_pkg::COUNT_W-1:0]     good_ff, bad_ff;
   logic                            fs_ff, lost_ff;
   logic                            restart, in_frame, done, fs, lost;
   logic [7:0]                      flags;
   logic [23:0]                     window;

   // normalizer
   logic [sfd_pkg::RAW_W-1:0]       raw;
   logic signed [12:0]              m;
   logic signed [17:0]              m20;
   logic signed [17:0]              t_biased;
   logic [14:0]                     u;
   logic [29:0]                     prod;
   logic [4:0]                      q;
   logic signed [17:0]              norm_wide;

   logic [sfd_pkg::CHAN_IDX_W-1:0]  out_idx_ff;
   logic [sfd_pkg::RAW_W-1:0]       out_raw_ff;
   logic signed [sfd_pkg::NORM_W-1:0] out_norm_ff;
   logic                            out_fs_ff, out_lost_ff, out_last_ff;
   logic [sfd_pkg::COUNT_W-1:0]     out_good_ff, out_bad_ff;

   always_comb begin
      restart  = (req_rx_byte == sfd_pkg::START_BYTE) && prev_zero_ff;
      pos_eff  = restart ? '0 : pos_ff;
      in_frame = pos_eff < sfd_pkg::POS_W'(sfd_pkg::FRAME_BYTES);
      done     = cmd.accept && (pos_eff == sfd_pkg::POS_W'(sfd_pkg::FRAME_BYTES - 1));
      pos_in   = in_frame ? pos_eff + 1'b1 : pos_eff;
      flags    = store_ff[sfd_pkg::FLAG_INDEX];
      fs       = flags[sfd_pkg::FAILSAFE_POS];
      lost     = !fs && flags[sfd_pkg::LOST_POS];
      status.frame_done = done;
   end

   // channels are packed LSB first from byte 1 on, 11 bits each
   always_comb begin
      window = '0;
      for (int ch = 0; ch < sfd_pkg::CHANNEL_COUNT; ch++) begin
         window = {store_ff[1 + (ch * 11) / 8 + 2],
                   store_ff[1 + (ch * 11) / 8 + 1],
                   store_ff[1 + (ch * 11) / 8]};
         unpacked[ch] = sfd_pkg::RAW_W'(window >> ((ch * 11) % 8));
      end
   end

   always_comb begin
      raw       = chan_ff[cmd.ch_idx];
      m         = $signed({2'b00, raw}) - 13'(sfd_pkg::RAW_MIN);
      m20       = (18'(m) <<< 4) + (18'(m) <<< 2);
      t_biased  = 18'(sfd_pkg::SPAN_BIAS) - ((18'(m) <<< 3) + (18'(m) <<< 2));
      u         = t_biased[14:0];
      prod      = 30'(u) * 30'(sfd_pkg::RECIP);
      q         = prod[29:sfd_pkg::RECIP_SHIFT];
      norm_wide = m20 + $signed({13'b0, q})
                  - 18'(sfd_pkg::BIAS_STEPS) - 18'(sfd_pkg::NORM_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && in_frame) begin
         store_ff[pos_eff] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         prev_zero_ff <= 1'b0;
         good_ff      <= '0;
         bad_ff       <= '0;
         for (int ch = 0; ch < sfd_pkg::CHANNEL_COUNT; ch++) begin
            chan_ff[ch] <= '0;
         end
      end else begin
         if (cmd.accept) begin
            pos_ff       <= pos_in;
            prev_zero_ff <= (req_rx_byte == sfd_pkg::ZERO_BYTE);
         end
         if (done) begin
            if (lost) begin
               bad_ff <= bad_ff + 1'b1;
            end else begin
               good_ff <= good_ff + 1'b1;
               for (int ch = 0; ch < sfd_pkg::CHANNEL_COUNT; ch++) begin
                  chan_ff[ch] <= unpacked[ch];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         fs_ff   <= fs;
         lost_ff <= lost;
      end
      if (cmd.load_out) begin
         out_idx_ff  <= cmd.ch_idx;
         out_raw_ff  <= raw;
         out_norm_ff <= norm_wide[sfd_pkg::NORM_W-1:0];
         out_fs_ff   <= fs_ff;
         out_lost_ff <= lost_ff;
         out_good_ff <= good_ff;
         out_bad_ff  <= bad_ff;
         out_last_ff <= (cmd.ch_idx ==
                         sfd_pkg::CHAN_IDX_W'(sfd_pkg::CHANNEL_COUNT - 1));
      end
   end

   assign rsp_channel_index = out_idx_ff;
   assign rsp_raw_value     = out_raw_ff;
   assign rsp_normalized    = out_norm_ff;
   assign rsp_failsafe      = out_fs_ff;
   assign rsp_frame_lost    = out_lost_ff;
   assign rsp_good_frames   = out_good_ff;
   assign rsp_bad_frames    = out_bad_ff;
   assign rsp_last          = out_last_ff;

endmodule

@@ verif/sbus_frame_decoder_checker.sv @@
`timescale 1ns / 100ps
// Channel word checker for the S.Bus frame decoder: predicts and compares result words.
module sbus_frame_decoder_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [sfd_pkg::CHAN_IDX_W-1:0]     rsp_channel_index,
   input  logic [sfd_pkg::RAW_W-1:0]          rsp_raw_value,
   input  logic signed [sfd_pkg::NORM_W-1:0]  rsp_normalized,
   input  logic                               rsp_failsafe,
   input  logic                               rsp_frame_lost,
   input  logic [sfd_pkg::COUNT_W-1:0]        rsp_good_frames,
   input  logic [sfd_pkg::COUNT_W-1:0]        rsp_bad_frames,
   input  logic                               rsp_last,
   output int unsigned                        error_count,
   output int unsigned                        words_pending
);

   localparam int RAW_SPAN = 1639;

   typedef struct packed {
      logic [sfd_pkg::CHAN_IDX_W-1:0] channel_index;
      logic [sfd_pkg::RAW_W-1:0]      raw_value;
      logic [sfd_pkg::NORM_W-1:0]     normalized;
      logic                           failsafe;
      logic                           frame_lost;
      logic [sfd_pkg::COUNT_W-1:0]    good_frames;
      logic [sfd_pkg::COUNT_W-1:0]    bad_frames;
      logic                           last;
   } chan_word_type;

   chan_word_type                expected_words[$];
   logic [7:0]                   frame_bytes [sfd_pkg::FRAME_BYTES];
   int unsigned                  write_pos;
   logic                         after_zero;
   logic [sfd_pkg::RAW_W-1:0]    channel_raw [sfd_pkg::CHANNEL_COUNT];
   logic [sfd_pkg::COUNT_W-1:0]  good_total;
   logic [sfd_pkg::COUNT_W-1:0]  bad_total;
   int unsigned                  error_total = 0;

   // Q2.14 with floor toward minus infinity
   function automatic logic [sfd_pkg::NORM_W-1:0] q214_of_raw(
      input logic [sfd_pkg::RAW_W-1:0] raw);
      longint num;
      longint quo;
      num = (longint'(raw) - sfd_pkg::RAW_MIN) * 32768;
      if (num >= 0) begin
         quo = num / RAW_SPAN;
      end else begin
         quo = -((-num + RAW_SPAN - 1) / RAW_SPAN);
      end
      quo = quo - sfd_pkg::NORM_OFFSET;
      return quo[sfd_pkg::NORM_W-1:0];
   endfunction

   task automatic decode_rx_byte(input logic [7:0] rx);
      logic [7:0]    flags;
      logic          fs;
      logic          lost;
      logic [23:0]   span;
      int            idx;
      chan_word_type w;
      if (rx == sfd_pkg::START_BYTE && after_zero) begin
         write_pos = 0;
      end
      after_zero = (rx == sfd_pkg::ZERO_BYTE);
      // drop bytes past a complete frame
      if (write_pos >= sfd_pkg::FRAME_BYTES) begin
         return;
      end
      frame_bytes[write_pos] = rx;
      write_pos++;
      if (write_pos != sfd_pkg::FRAME_BYTES) begin
         return;
      end
      flags = frame_bytes[sfd_pkg::FLAG_INDEX];
      fs    = flags[sfd_pkg::FAILSAFE_POS];
      lost  = !fs && flags[sfd_pkg::LOST_POS];
      if (lost) begin
         bad_total++;
      end else begin
         good_total++;
         // unpack 11-bit channels LSB-first from bytes 1..22
         for (int ch = 0; ch < sfd_pkg::CHANNEL_COUNT; ch++) begin
            idx  = 1 + ((ch * 11) >> 3);
            span = {frame_bytes[idx + 2], frame_bytes[idx + 1], frame_bytes[idx]};
            channel_raw[ch] = sfd_pkg::RAW_W'(span >> ((ch * 11) & 7));
         end
      end
      for (int ch = 0; ch < sfd_pkg::CHANNEL_COUNT; ch++) begin
         w.channel_index = sfd_pkg::CHAN_IDX_W'(ch);
         w.raw_value     = channel_raw[ch];
         w.normalized    = q214_of_raw(channel_raw[ch]);
         w.failsafe      = fs;
         w.frame_lost    = lost;
         w.good_frames   = good_total;
         w.bad_frames    = bad_total;
         w.last          = (ch == sfd_pkg::CHANNEL_COUNT - 1);
         expected_words.push_back(w);
      end
   endtask

   function automatic bit field_differs(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic check_word(input chan_word_type got);
      chan_word_type want;
      bit            bad;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected channel word: ch %0d raw %0h", $time, got.channel_index,
                  got.raw_value);
         error_total++;
         return;
      end
      want = expected_words.pop_front();
      bad  = 1'b0;
      bad |= field_differs("channel_index", want.channel_index, got.channel_index);
      bad |= field_differs("raw_value", want.raw_value, got.raw_value);
      bad |= field_differs("normalized", want.normalized, got.normalized);
      bad |= field_differs("failsafe", want.failsafe, got.failsafe);
      bad |= field_differs("frame_lost", want.frame_lost, got.frame_lost);
      bad |= field_differs("good_frames", want.good_frames, got.good_frames);
      bad |= field_differs("bad_frames", want.bad_frames, got.bad_frames);
      bad |= field_differs("last", want.last, got.last);
      if (bad) begin
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      chan_word_type seen;
      if (reset) begin
         expected_words.delete();
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         foreach (channel_raw[i]) channel_raw[i] = '0;
         write_pos  = 0;
         after_zero = 1'b0;
         good_total = '0;
         bad_total  = '0;
      end else begin
         // compare before predicting: a word leaving now never belongs to a byte taken now
         if (rsp_valid && !rsp_stall) begin
            seen.channel_index = rsp_channel_index;
            seen.raw_value     = rsp_raw_value;
            seen.normalized    = rsp_normalized;
            seen.failsafe      = rsp_failsafe;
            seen.frame_lost    = rsp_frame_lost;
            seen.good_frames   = rsp_good_frames;
            seen.bad_frames    = rsp_bad_frames;
            seen.last          = rsp_last;
            check_word(seen);
         end
         if (req_valid && !req_stall) begin
            decode_rx_byte(req_rx_byte);
         end
      end
      error_count   <= error_total;
      words_pending <= expected_words.size();
   end

endmodule

@@ verif/sbus_frame_decoder_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the S.Bus frame decoder: byte stimulus, stall pattern and verdict.
module sbus_frame_decoder_top_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DATA_BYTES    = sfd_pkg::FLAG_INDEX - 1;
   localparam int RANDOM_FRAMES = 4;
   localparam logic [7:0] FS_FLAG   = 8'h01 << sfd_pkg::FAILSAFE_POS;
   localparam logic [7:0] LOST_FLAG = 8'h01 << sfd_pkg::LOST_POS;

   typedef logic [7:0] payload_type [DATA_BYTES];

   logic                               clock;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_stall;
   logic [7:0]                         req_rx_byte = 8'h00;
   logic                               rsp_valid;
   logic                               rsp_stall   = 1'b0;
   logic [sfd_pkg::CHAN_IDX_W-1:0]     rsp_channel_index;
   logic [sfd_pkg::RAW_W-1:0]          rsp_raw_value;
   logic signed [sfd_pkg::NORM_W-1:0]  rsp_normalized;
   logic                               rsp_failsafe;
   logic                               rsp_frame_lost;
   logic [sfd_pkg::COUNT_W-1:0]        rsp_good_frames;
   logic [sfd_pkg::COUNT_W-1:0]        rsp_bad_frames;
   logic                               rsp_last;

   int unsigned tx_idle_pct = 19;
   int unsigned rx_idle_pct = 51;
   int unsigned cycle_count = 0;
   int unsigned error_count;
   int unsigned words_pending;

   sbus_frame_decoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_normalized    (rsp_normalized),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_frame_lost    (rsp_frame_lost),
      .rsp_good_frames   (rsp_good_frames),
      .rsp_bad_frames    (rsp_bad_frames),
      .rsp_last          (rsp_last)
   );

   sbus_frame_decoder_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_normalized    (rsp_normalized),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_frame_lost    (rsp_frame_lost),
      .rsp_good_frames   (rsp_good_frames),
      .rsp_bad_frames    (rsp_bad_frames),
      .rsp_last          (rsp_last),
      .error_count       (error_count),
      .words_pending     (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // hold the word until the decoder takes it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame(input payload_type payload, input logic [7:0] flags,
                             input logic [7:0] tail);
      send_byte(sfd_pkg::ZERO_BYTE);
      send_byte(sfd_pkg::START_BYTE);
      foreach (payload[i]) send_byte(payload[i]);
      send_byte(flags);
      send_byte(tail);
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   function automatic payload_type random_payload();
      payload_type p;
      foreach (p[i]) p[i] = 8'($urandom_range(255));
      return p;
   endfunction

   initial begin
      payload_type payload;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first frame straight after reset: no sync, odd start byte, all data ones
      send_byte(8'hA5);
      repeat (DATA_BYTES) send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h5A);
      // dropped bytes; a lone start byte does not resync
      send_byte(sfd_pkg::START_BYTE);
      send_byte(8'h3C);
      // all-zero data with failsafe and lost both set: still decoded
      send_frame('{default: 8'h00}, FS_FLAG | LOST_FLAG, sfd_pkg::ZERO_BYTE);
      // lost frame keeps the old channels
      send_frame('{default: 8'hFF}, LOST_FLAG, sfd_pkg::ZERO_BYTE);
      // truncated frame, then a restart; start byte mid-data without a zero ahead
      send_byte(sfd_pkg::ZERO_BYTE);
      send_byte(sfd_pkg::START_BYTE);
      repeat (8) send_byte(8'($urandom_range(255)));
      payload    = random_payload();
      payload[3] = 8'h11;
      payload[4] = sfd_pkg::START_BYTE;
      send_frame(payload, FS_FLAG, sfd_pkg::ZERO_BYTE);

      for (int f = 0; f < RANDOM_FRAMES; f++) begin
         if (f == RANDOM_FRAMES / 3) begin
            wait_for_results();
            tx_idle_pct = 51;
            rx_idle_pct = 19;
         end
         if (f == 2 * RANDOM_FRAMES / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case ($urandom_range(5))
            0: begin
               repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
            end
            1: begin
               send_byte(sfd_pkg::ZERO_BYTE);
               send_byte(sfd_pkg::START_BYTE);
               repeat ($urandom_range(23, 1)) send_byte(8'($urandom_range(255)));
            end
            default: ;
         endcase
         send_frame(random_payload(), 8'($urandom_range(255)),
                    $urandom_range(1) ? sfd_pkg::ZERO_BYTE : 8'($urandom_range(255)));
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && words_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/sfd_pkg.sv
src/sfd_controller.sv
src/sfd_datapath.sv
src/sbus_frame_decoder_top.sv
verif/sbus_frame_decoder_checker.sv
verif/sbus_frame_decoder_top_tb.sv
